/* src/ata_identify_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// ATA identify sequencer assertion macros
// Clocked assertion wrappers used by the checker file ais_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ATA_IDENTIFY_SEQUENCER_MACROS_SVH
`define ATA_IDENTIFY_SEQUENCER_MACROS_SVH

// check outside reset
`define AIS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define AIS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ais_pkg.sv */
// ----------------------------------------------------------------------------
// ais_pkg
// Shared types, codes and constants of the ATA identify sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ais_pkg;

  localparam int IDENTIFY_WORDS = 256;
  localparam int WORD_IDX_W     = $clog2(IDENTIFY_WORDS);
  localparam int RES_Q_DEPTH    = 4;
  localparam int RES_Q_PTR_W    = $clog2(RES_Q_DEPTH);
  localparam int RES_Q_CNT_W    = $clog2(RES_Q_DEPTH + 1);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  localparam logic [2:0] KIND_DRIVE   = 3'd0;
  localparam logic [2:0] KIND_CMD     = 3'd1;
  localparam logic [2:0] KIND_TEXT    = 3'd2;
  localparam logic [2:0] KIND_SUMMARY = 3'd3;
  localparam logic [2:0] KIND_FAIL    = 3'd4;

  localparam logic [7:0] FAIL_BSY_TIMEOUT = 8'd0;
  localparam logic [7:0] FAIL_DEV_ERROR   = 8'd1;
  localparam logic [7:0] FAIL_DRQ_TIMEOUT = 8'd2;

  localparam logic CFG_SLAVE_SELECT = 1'b0;
  localparam logic CFG_POLL_LIMIT   = 1'b1;

  localparam logic [7:0]  DEV_HEAD_BASE   = 8'hA0;
  localparam logic [7:0]  DEV_HEAD_SLAVE  = 8'h10;
  localparam logic [7:0]  CMD_IDENTIFY    = 8'hEC;
  localparam logic [31:0] POLL_LIMIT_RST  = 32'd100000;

  localparam int ST_BSY_BIT = 7;
  localparam int ST_DRQ_BIT = 3;
  localparam int ST_ERR_BIT = 0;

  localparam logic [7:0] W_SERIAL_FIRST = 8'd10;
  localparam logic [7:0] W_SERIAL_LAST  = 8'd19;
  localparam logic [7:0] W_FW_FIRST     = 8'd23;
  localparam logic [7:0] W_FW_LAST      = 8'd26;
  localparam logic [7:0] W_MODEL_FIRST  = 8'd27;
  localparam logic [7:0] W_MODEL_LAST   = 8'd46;
  localparam logic [7:0] W_DMA          = 8'd49;
  localparam logic [7:0] W_LBA28_LO     = 8'd60;
  localparam logic [7:0] W_LBA28_HI     = 8'd61;
  localparam logic [7:0] W_PIO          = 8'd64;
  localparam logic [7:0] W_LBA48_CAP    = 8'd83;
  localparam logic [7:0] W_UDMA         = 8'd88;
  localparam logic [7:0] W_LBA48_FIRST  = 8'd100;
  localparam logic [7:0] W_LBA48_LAST   = 8'd103;
  localparam logic [7:0] W_LAST         = 8'(IDENTIFY_WORDS - 1);

  localparam logic [1:0] SID_SERIAL = 2'd0;
  localparam logic [1:0] SID_FW     = 2'd1;
  localparam logic [1:0] SID_MODEL  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BSY  = 4'b0010,
    PH_DRQ  = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [15:0] text_word;
    logic [1:0]  string_id;
    logic [4:0]  word_offset;
    logic [5:0]  text_length;
    logic [63:0] sector_total;
    logic [2:0]  flags;
    logic [2:0]  dma_level;
    logic [1:0]  pio_level;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } eng_out_t;

  function automatic logic is_trim(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h00);
  endfunction

  function automatic logic [2:0] udma_best(input logic [15:0] w);
    logic [2:0] b;
    b = 3'd0;
    if (w[13]) begin
      for (int i = 0; i < 8; i++) begin
        if (w[i]) b = 3'(i);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/ais_engine.sv */
// ----------------------------------------------------------------------------
// ais_engine
// Sequencer state, configuration registers and per-request result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module ais_engine import ais_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        fire,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] value,
  output eng_out_t         eo
);

  logic        slave_select;
  logic [31:0] poll_limit;

  phase_t                phase, phase_next;
  logic [31:0]           poll_count, poll_count_next;
  logic [WORD_IDX_W-1:0] word_index, word_index_next;
  logic [31:0]           short_count, short_count_next;
  logic [63:0]           long_count, long_count_next;
  logic [1:0]            cap_bits, cap_bits_next;
  logic [2:0]            best_udma, best_udma_next;
  logic [1:0]            pio_bits, pio_bits_next;
  logic [5:0]            last_text_pos, last_text_pos_next;

  logic [7:0]  st;
  logic [31:0] poll_inc;
  logic        timeout;
  logic        in_text;
  logic [7:0]  text_first;
  logic [4:0]  text_last_off;
  logic [1:0]  sid;
  logic [4:0]  off;
  logic [5:0]  pos_base;
  logic [63:0] total;
  result_t     txt;
  result_t     sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_select <= 1'b0;
      poll_limit   <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLAVE_SELECT: slave_select <= cfg_data[0];
        CFG_POLL_LIMIT:   poll_limit   <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    st       = value[7:0];
    poll_inc = poll_count + 32'd1;
    timeout  = (poll_inc >= poll_limit);

    in_text       = 1'b1;
    text_first    = W_SERIAL_FIRST;
    text_last_off = 5'(W_SERIAL_LAST - W_SERIAL_FIRST);
    sid           = SID_SERIAL;
    if (word_index >= W_SERIAL_FIRST && word_index <= W_SERIAL_LAST) begin
      text_first    = W_SERIAL_FIRST;
      text_last_off = 5'(W_SERIAL_LAST - W_SERIAL_FIRST);
      sid           = SID_SERIAL;
    end else if (word_index >= W_FW_FIRST && word_index <= W_FW_LAST) begin
      text_first    = W_FW_FIRST;
      text_last_off = 5'(W_FW_LAST - W_FW_FIRST);
      sid           = SID_FW;
    end else if (word_index >= W_MODEL_FIRST && word_index <= W_MODEL_LAST) begin
      text_first    = W_MODEL_FIRST;
      text_last_off = 5'(W_MODEL_LAST - W_MODEL_FIRST);
      sid           = SID_MODEL;
    end else begin
      in_text = 1'b0;
    end
    off      = 5'(word_index - text_first);
    pos_base = {off, 1'b0};
    total    = cap_bits[0] ? long_count : {32'd0, short_count};

    phase_next         = phase;
    poll_count_next    = poll_count;
    word_index_next    = word_index;
    short_count_next   = short_count;
    long_count_next    = long_count;
    cap_bits_next      = cap_bits;
    best_udma_next     = best_udma;
    pio_bits_next      = pio_bits;
    last_text_pos_next = last_text_pos;

    txt = '0;
    sum = '0;
    eo  = '0;

    if (op == OP_START) begin
      eo.n               = 2'd2;
      eo.r0.kind         = KIND_DRIVE;
      eo.r0.code         = DEV_HEAD_BASE | (slave_select ? DEV_HEAD_SLAVE : 8'h00);
      eo.r1.kind         = KIND_CMD;
      eo.r1.code         = CMD_IDENTIFY;
      phase_next         = PH_BSY;
      poll_count_next    = '0;
      word_index_next    = '0;
      short_count_next   = '0;
      long_count_next    = '0;
      cap_bits_next      = '0;
      best_udma_next     = '0;
      pio_bits_next      = '0;
      last_text_pos_next = '0;
    end else if (op == OP_STATUS) begin
      unique case (phase)
        PH_BSY: begin
          if (st[ST_BSY_BIT]) begin
            poll_count_next = poll_inc;
            if (timeout) begin
              eo.n       = 2'd1;
              eo.r0.kind = KIND_FAIL;
              eo.r0.code = FAIL_BSY_TIMEOUT;
              phase_next = PH_IDLE;
            end
          end else if (st == 8'h00 || st[ST_ERR_BIT]) begin
            eo.n       = 2'd1;
            eo.r0.kind = KIND_FAIL;
            eo.r0.code = FAIL_DEV_ERROR;
            phase_next = PH_IDLE;
          end else begin
            phase_next      = PH_DRQ;
            poll_count_next = '0;
          end
        end
        PH_DRQ: begin
          if (st[ST_DRQ_BIT]) begin
            phase_next      = PH_DATA;
            word_index_next = '0;
          end else begin
            poll_count_next = poll_inc;
            if (timeout) begin
              eo.n       = 2'd1;
              eo.r0.kind = KIND_FAIL;
              eo.r0.code = FAIL_DRQ_TIMEOUT;
              phase_next = PH_IDLE;
            end
          end
        end
        PH_IDLE, PH_DATA: ;
        default: ;
      endcase
    end else if (op == OP_DATA && phase == PH_DATA) begin
      if (in_text) begin
        if (off == 5'd0) last_text_pos_next = '0;
        if (!is_trim(value[15:8])) last_text_pos_next = pos_base + 6'd1;
        if (!is_trim(value[7:0]))  last_text_pos_next = pos_base + 6'd2;
        txt.kind        = KIND_TEXT;
        txt.text_word   = value;
        txt.string_id   = sid;
        txt.word_offset = off;
        txt.text_length = (off == text_last_off) ? last_text_pos_next : 6'd0;
      end

      if (word_index == W_LBA28_LO) begin
        short_count_next[15:0] = value;
      end else if (word_index == W_LBA28_HI) begin
        short_count_next[31:16] = value;
      end else if (word_index >= W_LBA48_FIRST && word_index <= W_LBA48_LAST) begin
        unique case (word_index[1:0])
          2'd0: long_count_next[15:0]  = value;
          2'd1: long_count_next[31:16] = value;
          2'd2: long_count_next[47:32] = value;
          2'd3: long_count_next[63:48] = value;
          default: ;
        endcase
      end else if (word_index == W_LBA48_CAP) begin
        cap_bits_next[0] = value[10];
      end else if (word_index == W_DMA) begin
        cap_bits_next[1] = value[8];
      end else if (word_index == W_UDMA) begin
        best_udma_next = udma_best(value);
      end else if (word_index == W_PIO) begin
        pio_bits_next = value[1:0];
      end

      sum.kind         = KIND_SUMMARY;
      sum.sector_total = total;
      sum.flags        = {total != 64'd0, cap_bits};
      sum.dma_level    = best_udma;
      sum.pio_level    = pio_bits;

      if (word_index == W_LAST) begin
        phase_next      = PH_IDLE;
        word_index_next = '0;
        if (in_text) begin
          eo.n  = 2'd2;
          eo.r0 = txt;
          eo.r1 = sum;
        end else begin
          eo.n  = 2'd1;
          eo.r0 = sum;
        end
      end else begin
        word_index_next = word_index + WORD_IDX_W'(1);
        if (in_text) begin
          eo.n  = 2'd1;
          eo.r0 = txt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      poll_count    <= '0;
      word_index    <= '0;
      short_count   <= '0;
      long_count    <= '0;
      cap_bits      <= '0;
      best_udma     <= '0;
      pio_bits      <= '0;
      last_text_pos <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      poll_count    <= poll_count_next;
      word_index    <= word_index_next;
      short_count   <= short_count_next;
      long_count    <= long_count_next;
      cap_bits      <= cap_bits_next;
      best_udma     <= best_udma_next;
      pio_bits      <= pio_bits_next;
      last_text_pos <= last_text_pos_next;
    end
  end

endmodule

`default_nettype wire

/* src/ais_res_queue.sv */
// ----------------------------------------------------------------------------
// ais_res_queue
// Small result queue: up to two pushes per cycle, one pop when res_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ais_res_queue import ais_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  eng_out_t         eo,
  output logic             room2,
  output logic             res_valid,
  input  wire logic        res_ready,
  output result_t          res
);

  result_t                mem [RES_Q_DEPTH];
  logic [RES_Q_PTR_W-1:0] head, tail;
  logic [RES_Q_CNT_W-1:0] count, count_next;
  logic [RES_Q_CNT_W-1:0] n_in;
  logic                   pop;

  assign res_valid = (count != '0);
  assign res       = mem[head];
  assign pop       = res_valid && res_ready;
  assign room2     = (count <= RES_Q_CNT_W'(RES_Q_DEPTH - 2));
  assign n_in      = push ? RES_Q_CNT_W'(eo.n) : '0;
  assign count_next = count + n_in - RES_Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push && eo.n != 2'd0) begin
      mem[tail] <= eo.r0;
    end
    if (push && eo.n == 2'd2) begin
      mem[tail + RES_Q_PTR_W'(1)] <= eo.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + RES_Q_PTR_W'(pop);
      tail  <= tail + RES_Q_PTR_W'(n_in);
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

/* src/ata_identify_sequencer.sv */
// ----------------------------------------------------------------------------
// ata_identify_sequencer
// Host-side ATA IDENTIFY engine: register writes, status polling, string
// and capability extraction from the 256 identify words.
//
//   channel   signals                      role
//   request   item_valid/item_ready        op, value in
//   result    result_valid/result_ready    kind .. pio_level out
//   config    cfg_we, cfg_index, cfg_data  slave_select, poll_limit
//
// One request per cycle when not stalled; each is registered, then decoded.
// A request yields up to two results, held in a four-entry result queue
// and drained one per cycle while result_ready is high; requests stall while
// the queue has fewer than two free slots. Reset clears the sequencer to idle,
// empties the queue, and loads poll_limit with 100000 and slave_select with 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_identify_sequencer import ais_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] value,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [2:0]       kind,
  output logic [7:0]       code,
  output logic [15:0]      text_word,
  output logic [1:0]       string_id,
  output logic [4:0]       word_offset,
  output logic [5:0]       text_length,
  output logic [63:0]      sector_total,
  output logic [2:0]       flags,
  output logic [2:0]       dma_level,
  output logic [1:0]       pio_level
);

  logic        hold_valid;
  logic [1:0]  hold_op;
  logic [15:0] hold_value;
  logic        room2;
  logic        fire;
  eng_out_t    eo;
  result_t     res;

  assign fire       = hold_valid && room2;
  assign item_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold_op    <= op;
      hold_value <= value;
    end
  end

  ais_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .op        (hold_op),
    .value     (hold_value),
    .eo        (eo)
  );

  ais_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .eo        (eo),
    .room2     (room2),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (res)
  );

  assign kind         = res.kind;
  assign code         = res.code;
  assign text_word    = res.text_word;
  assign string_id    = res.string_id;
  assign word_offset  = res.word_offset;
  assign text_length  = res.text_length;
  assign sector_total = res.sector_total;
  assign flags        = res.flags;
  assign dma_level    = res.dma_level;
  assign pio_level    = res.pio_level;

endmodule

`default_nettype wire

/* src/ais_checker.sv */
// ----------------------------------------------------------------------------
// ais_checker
// Port-level checks of the ATA identify sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ata_identify_sequencer_macros.svh"

module ais_checker import ais_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [2:0]  kind,
  input wire logic [7:0]  code
);

  `AIS_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !result_valid, "result after reset")

  `AIS_ASSERT(a_hold_stalled,
    result_valid && !result_ready |=> result_valid && $stable(kind) && $stable(code),
    "stalled result changed")

  `AIS_ASSERT(a_cmd_after_drive,
    result_valid && kind == KIND_CMD |-> $past(result_valid) &&
    ($past(kind) == KIND_DRIVE || $past(kind) == KIND_CMD),
    "command write not after drive write")

  `AIS_ASSERT(a_drive_code,
    result_valid && kind == KIND_DRIVE |-> code[7:5] == 3'b101 && code[3:0] == 4'h0,
    "bad drive/head byte")

  `AIS_ASSERT(a_fail_code,
    result_valid && kind == KIND_FAIL |->
    code == FAIL_BSY_TIMEOUT || code == FAIL_DEV_ERROR || code == FAIL_DRQ_TIMEOUT,
    "bad failure code")

endmodule

bind ata_identify_sequencer ais_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .kind         (kind),
  .code         (code)
);

`default_nettype wire

/* tb/ata_identify_sequencer_test.sv */
// ----------------------------------------------------------------------------
// ATA identify sequencer testbench
// Drives start, status and identify-word requests through the valid/ready
// request port and checks every result against an in-bench model of the
// sequencer: register writes, poll timeouts, device errors, text words with
// trimmed lengths and the capacity summary. Runs directed corner cases, then
// random identify traffic under several stall profiles and configurations.
// ----------------------------------------------------------------------------
module ata_identify_sequencer_test;
  import ais_pkg::*;

  localparam logic [1:0] OP_SPARE       = 2'd3;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  op = '0;
  logic [15:0] value = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  code;
  logic [15:0] text_word;
  logic [1:0]  string_id;
  logic [4:0]  word_offset;
  logic [5:0]  text_length;
  logic [63:0] sector_total;
  logic [2:0]  flags;
  logic [2:0]  dma_level;
  logic [1:0]  pio_level;

  ata_identify_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .op(op), .value(value),
    .result_valid(result_valid), .result_ready(result_ready),
    .kind(kind), .code(code), .text_word(text_word), .string_id(string_id),
    .word_offset(word_offset), .text_length(text_length),
    .sector_total(sector_total), .flags(flags), .dma_level(dma_level),
    .pio_level(pio_level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic        cur_slave = 1'b0;
  logic [31:0] cur_poll_limit = POLL_LIMIT_RST;
  phase_t      seq_phase = PH_IDLE;
  logic [31:0] polls_used = '0;
  logic [7:0]  word_pos = '0;
  logic [31:0] lba28_count = '0;
  logic [63:0] lba48_count = '0;
  logic        has_lba48 = 1'b0;
  logic        has_dma = 1'b0;
  logic [2:0]  top_udma = '0;
  logic [1:0]  pio_field = '0;
  logic [5:0]  text_end = '0;

  result_t sequencer_results[$];
  result_t next_due;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failure_count = 0;
  int taken_requests = 0;
  int live_requests = 0;
  int checked_results = 0;
  int text_seen = 0;
  int summaries_seen = 0;
  int aborts_seen = 0;
  int quiet_cycles = 0;

  task automatic log_failure(input string msg);
    failure_count++;
    $display("MISMATCH t=%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) log_failure($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic push_failure(input logic [7:0] why);
    result_t r;
    r = '0;
    r.kind = KIND_FAIL;
    r.code = why;
    sequencer_results.push_back(r);
    seq_phase = PH_IDLE;
  endtask

  task automatic step_sequencer(input logic [1:0] o, input logic [15:0] v);
    result_t     r;
    logic [7:0]  st;
    logic [7:0]  off;
    logic [7:0]  str_len;
    logic [1:0]  sid;
    logic        in_text;
    logic [63:0] total;
    st = v[7:0];
    r = '0;
    off = '0;
    str_len = '0;
    sid = '0;
    case (o)
      OP_START: begin
        live_requests++;
        r.kind = KIND_DRIVE;
        r.code = DEV_HEAD_BASE | (cur_slave ? DEV_HEAD_SLAVE : 8'h00);
        sequencer_results.push_back(r);
        r = '0;
        r.kind = KIND_CMD;
        r.code = CMD_IDENTIFY;
        sequencer_results.push_back(r);
        seq_phase = PH_BSY;
        polls_used = '0;
        word_pos = '0;
        lba28_count = '0;
        lba48_count = '0;
        has_lba48 = 1'b0;
        has_dma = 1'b0;
        top_udma = '0;
        pio_field = '0;
        text_end = '0;
      end
      OP_STATUS: begin
        if (seq_phase == PH_BSY) begin
          live_requests++;
          if (st[ST_BSY_BIT]) begin
            polls_used++;
            if (polls_used >= cur_poll_limit) push_failure(FAIL_BSY_TIMEOUT);
          end else if (st == 8'h00 || st[ST_ERR_BIT]) begin
            push_failure(FAIL_DEV_ERROR);
          end else begin
            seq_phase = PH_DRQ;
            polls_used = '0;
          end
        end else if (seq_phase == PH_DRQ) begin
          live_requests++;
          if (st[ST_DRQ_BIT]) begin
            seq_phase = PH_DATA;
            word_pos = '0;
          end else begin
            polls_used++;
            if (polls_used >= cur_poll_limit) push_failure(FAIL_DRQ_TIMEOUT);
          end
        end
      end
      OP_DATA: begin
        if (seq_phase == PH_DATA) begin
          live_requests++;
          in_text = 1'b1;
          if (word_pos >= W_SERIAL_FIRST && word_pos <= W_SERIAL_LAST) begin
            off = word_pos - W_SERIAL_FIRST;
            str_len = 8'd10;
            sid = SID_SERIAL;
          end else if (word_pos >= W_FW_FIRST && word_pos <= W_FW_LAST) begin
            off = word_pos - W_FW_FIRST;
            str_len = 8'd4;
            sid = SID_FW;
          end else if (word_pos >= W_MODEL_FIRST && word_pos <= W_MODEL_LAST) begin
            off = word_pos - W_MODEL_FIRST;
            str_len = 8'd20;
            sid = SID_MODEL;
          end else begin
            in_text = 1'b0;
          end
          if (in_text) begin
            if (off == 8'd0) text_end = '0;
            if (v[15:8] != 8'h20 && v[15:8] != 8'h00) text_end = 6'(2 * off + 1);
            if (v[7:0] != 8'h20 && v[7:0] != 8'h00) text_end = 6'(2 * off + 2);
            r = '0;
            r.kind = KIND_TEXT;
            r.text_word = v;
            r.string_id = sid;
            r.word_offset = off[4:0];
            r.text_length = (off == str_len - 8'd1) ? text_end : 6'd0;
            sequencer_results.push_back(r);
          end
          case (word_pos)
            W_LBA28_LO:  lba28_count[15:0] = v;
            W_LBA28_HI:  lba28_count[31:16] = v;
            W_DMA:       has_dma = v[8];
            W_LBA48_CAP: has_lba48 = v[10];
            W_PIO:       pio_field = v[1:0];
            W_UDMA: begin
              top_udma = '0;
              if (v[13]) begin
                for (int b = 7; b >= 1; b--) begin
                  if (v[b] && top_udma == 3'd0) top_udma = 3'(b);
                end
              end
            end
            default: begin
              if (word_pos >= W_LBA48_FIRST && word_pos <= W_LBA48_LAST)
                lba48_count[16 * (word_pos - W_LBA48_FIRST) +: 16] = v;
            end
          endcase
          if (word_pos == W_LAST) begin
            total = has_lba48 ? lba48_count : {32'h0, lba28_count};
            r = '0;
            r.kind = KIND_SUMMARY;
            r.sector_total = total;
            r.flags = {total != 64'd0, has_dma, has_lba48};
            r.dma_level = top_udma;
            r.pio_level = pio_field;
            sequencer_results.push_back(r);
            seq_phase = PH_IDLE;
            word_pos = '0;
          end else begin
            word_pos = word_pos + 8'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] o, input logic [15:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    value <= v;
    do @(posedge clk); while (!item_ready);
    taken_requests++;
    step_sequencer(o, v);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sequencer_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic slave, input logic [31:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SLAVE_SELECT;
    cfg_data <= {31'h0, slave};
    @(posedge clk);
    cur_slave = slave;
    cfg_index <= CFG_POLL_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cur_poll_limit = limit;
    cfg_we <= 1'b0;
  endtask

  function automatic int polls_allowed();
    if (cur_poll_limit == 32'd0) return 1;
    if (cur_poll_limit > 32'd100) return 100;
    return int'(cur_poll_limit);
  endfunction

  function automatic logic [15:0] busy_status();
    return {8'($urandom), 8'h80 | 8'($urandom_range(127))};
  endfunction

  function automatic logic [15:0] clear_status();
    return {8'($urandom), 1'b0, 6'($urandom_range(63, 1)), 1'b0};
  endfunction

  function automatic logic [15:0] no_drq_status();
    return {8'($urandom), 8'($urandom) & 8'hF7};
  endfunction

  function automatic logic [7:0] pick_char(input bit padded);
    if (padded) return $urandom_range(1) ? 8'h20 : 8'h00;
    case ($urandom_range(9))
      0: return 8'h20;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(8'h7E, 8'h21));
    endcase
  endfunction

  function automatic logic [15:0] pick_identify_word(input int idx, input int pad_from,
                                                     input bit blank_counts);
    int pos;
    pos = 0;
    if (idx >= W_SERIAL_FIRST && idx <= W_SERIAL_LAST) begin
      pos = 2 * (idx - W_SERIAL_FIRST);
    end else if (idx >= W_FW_FIRST && idx <= W_FW_LAST) begin
      pos = 2 * (idx - W_FW_FIRST);
    end else if (idx >= W_MODEL_FIRST && idx <= W_MODEL_LAST) begin
      pos = 2 * (idx - W_MODEL_FIRST);
    end else begin
      if (blank_counts && (idx == W_LBA28_LO || idx == W_LBA28_HI ||
          (idx >= W_LBA48_FIRST && idx <= W_LBA48_LAST))) return 16'h0000;
      case ($urandom_range(7))
        0: return 16'h0000;
        1: return 16'hFFFF;
        default: return 16'($urandom);
      endcase
    end
    return {pick_char(pos >= pad_from), pick_char(pos + 1 >= pad_from)};
  endfunction

  task automatic send_identify(input int words);
    int nb;
    int nd;
    int pad_from;
    bit blank_counts;
    blank_counts = ($urandom_range(3) == 0);
    pad_from = 0;
    send_request(OP_START, 16'($urandom));
    nb = $urandom_range((polls_allowed() > 4) ? 3 : polls_allowed() - 1);
    nd = $urandom_range((polls_allowed() > 4) ? 3 : polls_allowed() - 1);
    repeat (nb) send_request(OP_STATUS, busy_status());
    send_request(OP_STATUS, clear_status());
    repeat (nd) send_request(OP_STATUS, no_drq_status());
    send_request(OP_STATUS, {8'($urandom), 8'($urandom) | 8'h08});
    for (int i = 0; i < words; i++) begin
      if (i == W_SERIAL_FIRST) pad_from = $urandom_range(20);
      else if (i == W_FW_FIRST) pad_from = $urandom_range(8);
      else if (i == W_MODEL_FIRST) pad_from = $urandom_range(40);
      if ($urandom_range(39) == 0)
        send_request($urandom_range(1) ? OP_STATUS : OP_SPARE, 16'($urandom));
      send_request(OP_DATA, pick_identify_word(i, pad_from, blank_counts));
    end
  endtask

  task automatic run_random_traffic(input int budget, input bit full_pass);
    int stop_at;
    int n;
    if (full_pass) send_identify(IDENTIFY_WORDS);
    stop_at = live_requests + budget;
    while (live_requests < stop_at) begin
      if ($urandom_range(11) == 0) drain();
      case ($urandom_range(11))
        0, 1, 2: send_identify($urandom_range(60, 1));
        3: begin
          send_request(OP_START, 16'($urandom));
          n = polls_allowed();
          if (n > 6) n = $urandom_range(6, 1);
          repeat (n) send_request(OP_STATUS, busy_status());
        end
        4: begin
          send_request(OP_START, 16'($urandom));
          if ($urandom_range(1)) send_request(OP_STATUS, busy_status());
          send_request(OP_STATUS, {8'($urandom), $urandom_range(1) ? 8'h00 :
                                   (8'($urandom_range(127)) | 8'h01)});
        end
        5: begin
          send_request(OP_START, 16'($urandom));
          send_request(OP_STATUS, clear_status());
          n = polls_allowed();
          if (n > 6) n = $urandom_range(6, 1);
          repeat (n) send_request(OP_STATUS, no_drq_status());
        end
        6, 7: begin
          repeat ($urandom_range(6, 1)) send_request(2'($urandom_range(3)), 16'($urandom));
        end
        default: send_identify($urandom_range(12, 1));
      endcase
    end
  endtask

  task automatic test_stray_items();
    send_request(OP_SPARE, 16'hFFFF);
    send_request(OP_STATUS, 16'h0080);
    send_request(OP_DATA, 16'hFFFF);
    send_request(OP_STATUS, 16'h0000);
    send_request(OP_START, 16'h0000);
    send_request(OP_DATA, 16'h0000);
    send_request(OP_SPARE, 16'h0000);
    send_request(OP_STATUS, 16'h00FF);
    send_request(OP_STATUS, 16'h0000);
  endtask

  task automatic test_device_errors();
    send_request(OP_START, 16'hFFFF);
    send_request(OP_STATUS, 16'h0001);
    send_request(OP_START, 16'h0000);
    send_request(OP_STATUS, 16'hFF50);
    send_request(OP_STATUS, 16'h00F7);
    send_request(OP_START, 16'h0000);
    send_request(OP_STATUS, 16'h0040);
    send_request(OP_STATUS, 16'hFF08);
    send_request(OP_DATA, 16'h5A5A);
    send_request(OP_START, 16'h0000);
    send_request(OP_STATUS, 16'h007F);
  endtask

  task automatic test_poll_limits();
    drain();
    set_config(1'b1, 32'd0);
    send_request(OP_START, 16'h0000);
    send_request(OP_STATUS, 16'h0080);
    send_request(OP_START, 16'h0000);
    send_request(OP_STATUS, 16'h0050);
    send_request(OP_STATUS, 16'h0000);
    drain();
    set_config(1'b0, 32'd2);
    send_request(OP_START, 16'h0000);
    send_request(OP_STATUS, 16'h0080);
    send_request(OP_STATUS, 16'h00FF);
  endtask

  task automatic test_steady_stream();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(1'b0, 32'hFFFF_FFFF);
    run_random_traffic(20, 1'b0);
  endtask

  task automatic test_sender_gaps();
    drain();
    send_idle_pct = 61;
    recv_stall_pct = 0;
    set_config(1'b1, 32'd1);
    run_random_traffic(20, 1'b0);
  endtask

  task automatic test_receiver_backpressure();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 61;
    set_config(1'b0, 32'd0);
    run_random_traffic(20, 1'b1);
  endtask

  task automatic test_mixed_stalls();
    drain();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    set_config(1'b1, 32'($urandom_range(6, 3)));
    run_random_traffic(20, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        checked_results++;
        if (sequencer_results.size() == 0) begin
          log_failure($sformatf("result kind %0d with nothing pending", kind));
        end else begin
          next_due = sequencer_results.pop_front();
          if (next_due.kind == KIND_TEXT) text_seen++;
          if (next_due.kind == KIND_SUMMARY) summaries_seen++;
          if (next_due.kind == KIND_FAIL) aborts_seen++;
          check_field("kind", 64'(kind), 64'(next_due.kind));
          check_field("code", 64'(code), 64'(next_due.code));
          check_field("text_word", 64'(text_word), 64'(next_due.text_word));
          check_field("string_id", 64'(string_id), 64'(next_due.string_id));
          check_field("word_offset", 64'(word_offset), 64'(next_due.word_offset));
          check_field("text_length", 64'(text_length), 64'(next_due.text_length));
          check_field("sector_total", sector_total, next_due.sector_total);
          check_field("flags", 64'(flags), 64'(next_due.flags));
          check_field("dma_level", 64'(dma_level), 64'(next_due.dma_level));
          check_field("pio_level", 64'(pio_level), 64'(next_due.pio_level));
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               quiet_cycles, sequencer_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_stray_items();
    test_device_errors();
    test_poll_limits();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_stalls();
    drain();
    $display("Sent %0d requests (%0d acted on) under four stall profiles, both drives,",
             taken_requests, live_requests);
    $display("poll limits 0/1/small/default/max; checked %0d results:",
             checked_results);
    $display("  %0d text, %0d summary, %0d abort",
             text_seen, summaries_seen, aborts_seen);
    if (failure_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/ais_pkg.sv
src/ais_engine.sv
src/ais_res_queue.sv
src/ata_identify_sequencer.sv
src/ais_checker.sv
tb/ata_identify_sequencer_test.sv
